// File: hw/rtl/mif_pkg.sv
// Shared types and constants for the median image filter.
// Holds field widths, register indexes and the controller/datapath structs.
// No dependencies.
package mif_pkg;

    localparam int PIX_W  = 8;   // grey sample width
    localparam int CFG_W  = 11;  // widest configuration register
    localparam int SIZE_W = 4;   // window_size register width
    localparam int HALF_W = SIZE_W - 1;
    localparam int ROW_W  = 11;  // row counter width, wraps at 2048
    localparam int IDX_W  = 2;   // configuration register index width
    localparam int BIT_W  = 3;   // bit position within a pixel

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_WINDOW = 9;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

    localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 11'd512;
    localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 11'd512;
    localparam logic [SIZE_W-1:0] RST_WINDOW_SIZE  = 4'd3;

    typedef struct packed {
        logic              accept;       // take the input beat, shift the window
        logic              rd_issue;     // read one stored row at rd_idx
        logic [SIZE_W-1:0] rd_idx;
        logic              pos;          // locate the output, store pixel, advance
        logic              rank_count;   // count zeros at bit_idx per window row
        logic              rank_decide;  // settle one result bit
        logic [BIT_W-1:0]  bit_idx;
        logic              load_out;     // move the result into the output stage
    } dp_cmd_t;

    typedef struct packed {
        logic              emit;         // this item yields a result
        logic [SIZE_W-1:0] size;         // window side in use
        logic              out_busy;     // output stage cannot take a result
    } dp_status_t;

endpackage

// File: hw/rtl/median_image_filter.sv
// Median image filter, top level: configuration registers, sequencer and
// datapath. Depends on mif_pkg, mif_ctrl, mif_datapath (and mif_ram below it).
//
// Streaming 2-D median filter for 8-bit grey frames sent in raster order,
// one pixel per input beat. For each centre pixel the block ranks the
// window_size x window_size neighbourhood (positions outside the frame count
// as zero) and returns the middle value. Output trails input by
// (size/2)*width + size/2 beats, so after the frame send that many beats with
// tuser set as filler to drain it; the final output carries tlast. Items are
// handled one at a time: each item is accepted, then size-1 row store reads
// go through its single read port and the position check follows; an item
// that yields an output then runs the eight-bit rank search over the window,
// settling one result bit per step, MSB first. A finished result waits in an
// output register while the next item is taken. Write configuration only
// between frames or while the block is idle; even window sizes act as the
// next lower odd size, and out-of-range values are clamped.
module median_image_filter import mif_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // [7:0] pixel
    input  logic              s_tuser,   // [0] filler
    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PIX_W-1:0]  m_tdata,   // [7:0] filtered_pixel
    output logic              m_tlast    // frame_last
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int EXW = 16;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [SIZE_W-1:0] size_reg;

    // Hold the raw register values; clamp when used
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            size_reg   <= RST_WINDOW_SIZE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                REG_WINDOW_SIZE:  size_reg   <= cfg_wdata[SIZE_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    logic [EXW-1:0]    width_ext, height_ext;
    logic [WW-1:0]     width_used;
    logic [HW-1:0]     height_used;
    logic [SIZE_W-1:0] size_clamp, size_used;

    assign width_ext  = EXW'(width_reg);
    assign height_ext = EXW'(height_reg);

    always_comb begin
        if (width_ext == '0) begin
            width_used = WW'(1);
        end else if (width_ext > EXW'(MAX_WIDTH)) begin
            width_used = WW'(MAX_WIDTH);
        end else begin
            width_used = WW'(width_ext);
        end
        if (height_ext == '0) begin
            height_used = HW'(1);
        end else if (height_ext > EXW'(MAX_HEIGHT)) begin
            height_used = HW'(MAX_HEIGHT);
        end else begin
            height_used = HW'(height_ext);
        end
        if (size_reg < SIZE_W'(3)) begin
            size_clamp = SIZE_W'(3);
        end else if (size_reg > SIZE_W'(MAX_WINDOW)) begin
            size_clamp = SIZE_W'(MAX_WINDOW);
        end else begin
            size_clamp = size_reg;
        end
        // even sides act as the next lower odd side
        size_used = size_clamp[0] ? size_clamp : size_clamp - SIZE_W'(1);
    end

    dp_cmd_t    cmd;
    dp_status_t status;

    mif_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mif_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .width_used  (width_used),
        .height_used (height_used),
        .size_used   (size_used),
        .s_pixel     (s_tdata),
        .s_filler    (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_pixel     (m_tdata),
        .m_last      (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// File: hw/rtl/mif_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/mif_ctrl.sv
// Sequencer of the median image filter: one item at a time through
// accept, row reads, position check, bit-serial ranking and output load.
// Depends on mif_pkg.
module mif_ctrl import mif_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_POS    = 6'b000100,
        ST_RANK_A = 6'b001000,
        ST_RANK_B = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [SIZE_W-1:0] size_m1;

    assign size_m1 = status.size - SIZE_W'(1);

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        cmd.rd_idx  = rd_cnt_reg;
        cmd.bit_idx = bit_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept  = 1'b1;
                    rd_cnt_next = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = (rd_cnt_reg < size_m1);
                if (rd_cnt_reg == size_m1) begin
                    state_next = ST_POS;
                end else begin
                    rd_cnt_next = rd_cnt_reg + SIZE_W'(1);
                end
            end
            ST_POS: begin
                cmd.pos = 1'b1;
                if (status.emit) begin
                    bit_next   = '1;
                    state_next = ST_RANK_A;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RANK_A: begin
                cmd.rank_count = 1'b1;
                state_next     = ST_RANK_B;
            end
            ST_RANK_B: begin
                cmd.rank_decide = 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_RANK_A;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
            bit_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            bit_reg    <= bit_next;
        end
    end

endmodule

// File: hw/rtl/mif_datapath.sv
// Datapath of the median image filter: position counters, row store,
// window registers, bit-serial rank selection and the output stage.
// Depends on mif_pkg and mif_ram.
module mif_datapath import mif_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_used,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height_used,
    input  logic [SIZE_W-1:0]                 size_used,
    input  logic [PIX_W-1:0]                  s_pixel,
    input  logic                              s_filler,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [PIX_W-1:0]                  m_pixel,
    output logic                              m_last,
    input  dp_cmd_t                           cmd,
    output dp_status_t                        status
);

    localparam int MW    = MAX_WINDOW;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RK    = MAX_WINDOW - 1;
    localparam int SLW   = $clog2(RK);
    localparam int DEPTH = RK << CW;
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF_MAX = MAX_WINDOW / 2;
    localparam int KW    = $clog2(MAX_WINDOW * MAX_WINDOW / 2 + 1);
    localparam int CNW   = $clog2(MAX_WINDOW + 1);
    localparam int ZW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int RSW   = ((ROW_W > HW) ? ROW_W : HW) + 2;
    localparam int CSW   = WW + 2;
    localparam int SUMW  = SLW + SIZE_W + 1;
    localparam logic signed [RSW-1:0] RONE = RSW'(1);
    localparam logic signed [CSW-1:0] CONE = CSW'(1);

    // Position and slot counters
    logic [CW-1:0]    item_col_reg, item_col_next;
    logic [ROW_W-1:0] item_row_reg, item_row_next;
    logic [SLW-1:0]   item_slot_reg, item_slot_next;
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [SLW-1:0]   slot_reg;
    logic [PIX_W-1:0] pix_reg;

    // Window, read tracking and ranking state
    logic [PIX_W-1:0]  win_reg [MW][MW];
    logic              rd_valid_reg;
    logic [SIZE_W-1:0] rd_k_reg;
    logic [MW-1:0]     cand_reg [MW];
    logic [CNW-1:0]    cnt_reg [MW];
    logic [MW-1:0]     rowok_reg, colok_reg;
    logic [KW-1:0]     kleft_reg;
    logic [PIX_W-1:0]  res_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [HALF_W-1:0] half;
    logic [SLW-1:0]    slot_inc_item, slot_inc_cur;
    logic [ROW_W-1:0]  row_inc_item, row_inc_cur;

    assign half = size_used[SIZE_W-1:1];

    function automatic logic [SLW-1:0] slot_step(input logic [SLW-1:0] s,
                                                 input logic [ROW_W-1:0] new_row);
        logic [SLW-1:0] r;
        if (new_row == '0) begin
            r = '0;
        end else if (s == SLW'(RK - 1)) begin
            r = '0;
        end else begin
            r = s + SLW'(1);
        end
        return r;
    endfunction

    assign row_inc_item  = item_row_reg + ROW_W'(1);
    assign row_inc_cur   = row_reg + ROW_W'(1);
    assign slot_inc_item = slot_step(item_slot_reg, row_inc_item);
    assign slot_inc_cur  = slot_step(slot_reg, row_inc_cur);

    // Row store read address: slot of the row rd_back rows up
    logic [SIZE_W-1:0] rd_back;
    logic [SUMW-1:0]   slot_sum;
    logic [SLW-1:0]    rd_slot;
    logic [PIX_W-1:0]  ram_rdata;

    assign rd_back  = size_used - SIZE_W'(1) - cmd.rd_idx;
    assign slot_sum = SUMW'(slot_reg) + SUMW'(RK) - SUMW'(rd_back);
    assign rd_slot  = (slot_sum >= SUMW'(RK)) ? SLW'(slot_sum - SUMW'(RK)) : SLW'(slot_sum);

    mif_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (cmd.pos),
        .waddr (AW'({slot_reg, col_reg})),
        .wdata (pix_reg),
        .raddr (AW'({rd_slot, col_reg})),
        .rdata (ram_rdata)
    );

    // Output position relative to the current item
    logic signed [CSW-1:0] pc;
    logic signed [RSW-1:0] pr;
    logic signed [RSW-1:0] hs;
    logic signed [CSW-1:0] wsg;
    logic signed [RSW-1:0] fr;
    logic signed [CSW-1:0] fc;
    logic                  emit_c, last_c;
    logic [MW-1:0]         rowok_c, colok_c;

    assign hs  = $signed(RSW'(height_used));
    assign wsg = $signed(CSW'(width_used));

    always_comb begin
        pc = $signed(CSW'(col_reg)) - $signed(CSW'(half));
        pr = $signed(RSW'(row_reg)) - $signed(RSW'(half));
        for (int i = 0; i < HALF_MAX; i++) begin
            if (pc < 0) begin
                pc = pc + wsg;
                pr = pr - RONE;
            end
        end
        emit_c = (pr >= 0) && (pr < hs);
        last_c = (pr == hs - RONE) && (pc == wsg - CONE);
        for (int k = 0; k < MW; k++) begin
            fr = pr - $signed(RSW'(half)) + $signed(RSW'(k));
            rowok_c[k] = (fr >= 0) && (fr < hs);
        end
        for (int j = 0; j < MW; j++) begin
            fc = pc + $signed(CSW'(j)) - $signed(CSW'(MW - 1)) + $signed(CSW'(half));
            colok_c[j] = (fc >= 0) && (fc < wsg);
        end
    end

    // Bit plane of the effective window values and zero counts
    logic [MW-1:0]   bitval [MW];
    logic [CNW-1:0]  cnt_c [MW];
    logic [ZW-1:0]   zeros;
    logic            take_zero;
    logic [PIX_W*2-1:0] size_sq;

    always_comb begin
        for (int k = 0; k < MW; k++) begin
            cnt_c[k] = '0;
            for (int j = 0; j < MW; j++) begin
                bitval[k][j] = rowok_reg[k] && colok_reg[j] && win_reg[k][j][cmd.bit_idx];
                if (cand_reg[k][j] && !bitval[k][j]) begin
                    cnt_c[k] = cnt_c[k] + CNW'(1);
                end
            end
        end
        zeros = '0;
        for (int k = 0; k < MW; k++) begin
            zeros = zeros + ZW'(cnt_reg[k]);
        end
        take_zero = (ZW'(kleft_reg) < zeros);
    end

    assign size_sq = (PIX_W*2)'(size_used) * (PIX_W*2)'(size_used);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_col_reg  <= '0;
            item_row_reg  <= '0;
            item_slot_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MW; k++) begin
                for (int j = 0; j < MW; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else begin
            item_col_reg  <= item_col_next;
            item_row_reg  <= item_row_next;
            item_slot_reg <= item_slot_next;
            rd_valid_reg  <= cmd.rd_issue;
            if (cmd.accept) begin
                // shift every window row left, drop in the new column
                for (int k = 0; k < MW; k++) begin
                    for (int j = 0; j < MW - 1; j++) begin
                        win_reg[k][j] <= win_reg[k][j+1];
                    end
                    win_reg[k][MW-1] <= (k == int'(size_used) - 1) ?
                                        (s_filler ? '0 : s_pixel) : '0;
                end
            end else if (rd_valid_reg) begin
                win_reg[rd_k_reg][MW-1] <= ram_rdata;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Counter advance: wrap a stale column first on accept, step after the item
    always_comb begin
        item_col_next  = item_col_reg;
        item_row_next  = item_row_reg;
        item_slot_next = item_slot_reg;
        if (cmd.pos) begin
            if (emit_c && last_c) begin
                item_col_next  = '0;
                item_row_next  = '0;
                item_slot_next = '0;
            end else if (WW'(col_reg) + WW'(1) >= width_used) begin
                item_col_next  = '0;
                item_row_next  = row_inc_cur;
                item_slot_next = slot_inc_cur;
            end else begin
                item_col_next  = col_reg + CW'(1);
                item_row_next  = row_reg;
                item_slot_next = slot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= s_filler ? '0 : s_pixel;
            if (WW'(item_col_reg) >= width_used) begin
                col_reg  <= '0;
                row_reg  <= row_inc_item;
                slot_reg <= slot_inc_item;
            end else begin
                col_reg  <= item_col_reg;
                row_reg  <= item_row_reg;
                slot_reg <= item_slot_reg;
            end
        end
        if (cmd.rd_issue) begin
            rd_k_reg <= cmd.rd_idx;
        end
        if (cmd.pos) begin
            rowok_reg <= rowok_c;
            colok_reg <= colok_c;
            last_reg  <= last_c;
            kleft_reg <= KW'(size_sq >> 1);
            res_reg   <= '0;
            for (int k = 0; k < MW; k++) begin
                for (int j = 0; j < MW; j++) begin
                    cand_reg[k][j] <= (k < int'(size_used)) && (j >= MW - int'(size_used));
                end
            end
        end
        if (cmd.rank_count) begin
            for (int k = 0; k < MW; k++) begin
                cnt_reg[k] <= cnt_c[k];
            end
        end
        if (cmd.rank_decide) begin
            // keep the candidates on the side that holds the wanted rank
            res_reg[cmd.bit_idx] <= !take_zero;
            if (!take_zero) begin
                kleft_reg <= KW'(ZW'(kleft_reg) - zeros);
            end
            for (int k = 0; k < MW; k++) begin
                cand_reg[k] <= cand_reg[k] & (take_zero ? ~bitval[k] : bitval[k]);
            end
        end
        if (cmd.load_out) begin
            out_data_reg <= res_reg;
            out_last_reg <= last_reg;
        end
    end

    assign status.emit     = emit_c;
    assign status.size     = size_used;
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_pixel  = out_data_reg;
    assign m_last   = out_last_reg;

endmodule
